[rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 offset map.
// Used by the output channel interface, the decoder, the result queue and the top level.
package u8u16_pkg;

  localparam int unsigned FieldBits  = 16;
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntBits    = $clog2(MaxResults + 1);
  localparam int unsigned AccBits    = 21;

  localparam logic [7:0] Lead4Min = 8'hf0;
  localparam logic [7:0] Lead3Min = 8'he0;
  localparam logic [7:0] Lead2Min = 8'hc0;
  localparam logic [1:0] ContTag  = 2'b10;

  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] Lead3Mask = 8'h0f;
  localparam logic [7:0] Lead2Mask = 8'h1f;

  // One result as it leaves the block, fields already cut to 16 bits.
  typedef struct packed {
    logic [FieldBits-1:0] byte_offset;
    logic [FieldBits-1:0] unit_index;
    logic                 end_marker;
  } u8u16_res_t;

  // All results caused by one input byte, head at index 0.
  typedef struct packed {
    u8u16_res_t [MaxResults-1:0] res;
    logic [CntBits-1:0]          cnt;
  } u8u16_bundle_t;

endpackage

[rtl/u8u16_if.sv]
// Valid/ready channel interfaces for the UTF-8 to UTF-16 offset map.
// Depends on u8u16_pkg for field widths.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8u16_out_if
  import u8u16_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [FieldBits-1:0] byte_offset;
  logic [FieldBits-1:0] unit_index;
  logic                 end_marker;
  logic                 run_last;

  modport source (output valid, output byte_offset, output unit_index,
                  output end_marker, output run_last, input ready);
  modport sink   (input valid, input byte_offset, input unit_index,
                  input end_marker, input run_last, output ready);
endinterface

[rtl/u8u16_decode.sv]
// Decoder state and single-pass result generation for one text byte.
// Depends on u8u16_pkg for the result bundle type and byte class constants.
module u8u16_decode
  import u8u16_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    text_byte_i,
  input  logic          final_byte_i,
  output u8u16_bundle_t bundle_o
);

  localparam int unsigned OB = OFFSET_BITS;

  logic [1:0]         pc_q, pc_d;
  logic [1:0]         ee_q, ee_d;
  logic [OB-1:0]      lead_q, lead_d;
  logic [OB-1:0]      pos_q, pos_d;
  logic [OB-1:0]      uc_q, uc_d;
  logic [AccBits-1:0] acc_q, acc_d;

  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a, input logic [2:0] k);
    logic [OB:0] s;
    s = {1'b0, a} + (OB+1)'(k);
    return s[OB] ? {OB{1'b1}} : s[OB-1:0];
  endfunction

  function automatic logic [FieldBits-1:0] cut16(input logic [OB-1:0] x);
    logic [OB+FieldBits-1:0] e;
    e = (OB+FieldBits)'(x);
    return e[FieldBits-1:0];
  endfunction

  logic               is_cont, hold, cont_hit, complete, start, start_lead;
  logic [1:0]         extra;
  logic [7:0]         lead_mask;
  logic [AccBits-1:0] acc_a;
  logic [2:0]         g1_n, g2_n, g3_n, nu, k;
  logic [1:0]         pc_n;
  logic [OB-1:0]      lead_n, off;

  always_comb begin
    is_cont  = text_byte_i[7:6] == ContTag;
    hold     = pc_q != 2'd0;
    cont_hit = hold && is_cont;
    acc_a    = {acc_q[AccBits-7:0], text_byte_i[5:0]};
    complete = cont_hit && (pc_q >= ee_q);

    if (text_byte_i >= Lead4Min) begin
      extra = 2'd3;
      lead_mask = Lead4Mask;
    end else if (text_byte_i >= Lead3Min) begin
      extra = 2'd2;
      lead_mask = Lead3Mask;
    end else if (text_byte_i >= Lead2Min) begin
      extra = 2'd1;
      lead_mask = Lead2Mask;
    end else begin
      extra = 2'd0;
      lead_mask = Lead2Mask;
    end

    start      = !cont_hit;
    start_lead = start && (extra != 2'd0);

    // first group: completed sequence (one or two units at the lead) or a broken flush
    if (cont_hit) g1_n = complete ? ((|acc_a[AccBits-1:16]) ? 3'd2 : 3'd1) : 3'd0;
    else          g1_n = {1'b0, pc_q};
    g2_n = {2'b00, start && (extra == 2'd0)};

    if (cont_hit)        pc_n = complete ? 2'd0 : pc_q + 2'd1;
    else if (start_lead) pc_n = 2'd1;
    else                 pc_n = 2'd0;
    lead_n = start_lead ? pos_q : lead_q;

    g3_n = final_byte_i ? {1'b0, pc_n} : 3'd0;
    nu   = g1_n + g2_n + g3_n;

    bundle_o.cnt = (CntBits)'(nu) + (CntBits)'(final_byte_i);
    for (int j = 0; j < MaxResults; j++) begin
      k   = 3'(j) - g1_n - g2_n;
      off = sat_add(lead_n, k);
      if (3'(j) < g1_n)             off = cont_hit ? lead_q : sat_add(lead_q, 3'(j));
      else if (3'(j) < g1_n + g2_n) off = pos_q;
      if (3'(j) < nu) begin
        bundle_o.res[j].byte_offset = cut16(off);
        bundle_o.res[j].unit_index  = cut16(sat_add(uc_q, 3'(j)));
        bundle_o.res[j].end_marker  = 1'b0;
      end else begin
        bundle_o.res[j].byte_offset = cut16(sat_add(pos_q, 3'd1));
        bundle_o.res[j].unit_index  = cut16(sat_add(uc_q, nu));
        bundle_o.res[j].end_marker  = 1'b1;
      end
    end

    pc_d   = pc_q;
    ee_d   = ee_q;
    lead_d = lead_q;
    pos_d  = pos_q;
    uc_d   = uc_q;
    acc_d  = acc_q;
    if (fire_i) begin
      if (final_byte_i) begin
        // text done: back to the reset state
        pc_d   = '0;
        ee_d   = '0;
        lead_d = '0;
        pos_d  = '0;
        uc_d   = '0;
        acc_d  = '0;
      end else begin
        pc_d   = pc_n;
        lead_d = lead_n;
        pos_d  = sat_add(pos_q, 3'd1);
        uc_d   = sat_add(uc_q, nu);
        if (start_lead) begin
          ee_d  = extra;
          acc_d = (AccBits)'(text_byte_i & lead_mask);
        end else if (cont_hit) begin
          acc_d = acc_a;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      ee_q   <= '0;
      lead_q <= '0;
      pos_q  <= '0;
      uc_q   <= '0;
      acc_q  <= '0;
    end else begin
      pc_q   <= pc_d;
      ee_q   <= ee_d;
      lead_q <= lead_d;
      pos_q  <= pos_d;
      uc_q   <= uc_d;
      acc_q  <= acc_d;
    end
  end

endmodule

[rtl/u8u16_emit.sv]
// Result queue: a shifting output bundle plus one waiting bundle.
// Depends on u8u16_pkg for the bundle type; head entry drives the output channel.
module u8u16_emit
  import u8u16_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8u16_bundle_t bundle_i,
  output logic          in_ready_o,
  u8u16_out_if.source   out_o
);

  u8u16_res_t [MaxResults-1:0] cur_q, cur_d;
  logic [CntBits-1:0]          cnt_q, cnt_d;
  u8u16_bundle_t               nxt_q, nxt_d;
  logic                        nxt_v_q, nxt_v_d;
  logic                        out_fire, cur_free, load;

  assign out_fire   = (cnt_q != '0) && out_o.ready;
  assign cur_free   = (cnt_q == '0) || ((cnt_q == CntBits'(1)) && out_o.ready);
  assign in_ready_o = !nxt_v_q || cur_free;
  assign load       = push_i && (bundle_i.cnt != '0);

  always_comb begin
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    nxt_d   = nxt_q;
    nxt_v_d = nxt_v_q;
    if (cur_free) begin
      if (nxt_v_q) begin
        cur_d   = nxt_q.res;
        cnt_d   = nxt_q.cnt;
        nxt_d   = bundle_i;
        nxt_v_d = load;
      end else if (load) begin
        cur_d = bundle_i.res;
        cnt_d = bundle_i.cnt;
      end else begin
        cnt_d = '0;
      end
    end else begin
      if (out_fire) begin
        for (int i = 0; i < MaxResults - 1; i++) cur_d[i] = cur_q[i+1];
        cnt_d = cnt_q - CntBits'(1);
      end
      if (load) begin
        nxt_d   = bundle_i;
        nxt_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      nxt_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      nxt_v_q <= nxt_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nxt_q <= nxt_d;
  end

  assign out_o.valid       = cnt_q != '0;
  assign out_o.byte_offset = cur_q[0].byte_offset;
  assign out_o.unit_index  = cur_q[0].unit_index;
  assign out_o.end_marker  = cur_q[0].end_marker;
  assign out_o.run_last    = cnt_q == CntBits'(1);

endmodule

[rtl/utf8_to_utf16_offset_map.sv]
// UTF-8 to UTF-16 offset map: one text byte per transfer in, one result per transfer out.
// The first result of a byte is driven from the registered result queue, not combinationally.
// Throughput: 1 byte per cycle unless the result queue is full; a byte with N results takes N output transfers,
// bytes with no result take no output transfer; a one-bundle queue absorbs bursts.
// Reset: asynchronous, active low; clears decoder state and the result queue.
// Decoder state also returns to reset after each final byte.
module utf8_to_utf16_offset_map
  import u8u16_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8u16_in_if.sink    in_i,
  u8u16_out_if.source out_o
);

  u8u16_bundle_t bundle;
  logic          in_ready;
  logic          in_fire;

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  u8u16_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .text_byte_i (in_i.text_byte),
    .final_byte_i(in_i.final_byte),
    .bundle_o    (bundle)
  );

  u8u16_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_fire),
    .bundle_i  (bundle),
    .in_ready_o(in_ready),
    .out_o     (out_o)
  );

  a_bundle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (bundle.cnt <= CntBits'(MaxResults)))
    else $error("result bundle larger than the queue entry");

  a_final_has_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.final_byte) |-> (bundle.cnt != '0))
    else $error("final byte produced no end result");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.end_marker) |-> out_o.run_last)
    else $error("end marker not on the last result of its byte");

  a_stall_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_o.valid)
    else $error("input stalled with no pending output transfer");

endmodule
